FILE: rtl/bpc_pkg.sv
// Shared types, field widths, register indexes and scale tables of the pressure compensation core.
package bpc_pkg;

	localparam int RAW_W      = 24;
	localparam int TEMP_W     = 24;
	localparam int PRES_W     = 32;
	localparam int OSR_W      = 3;
	localparam int CALIB_W    = 48;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 48;

	// Odd part of a scale factor, and restoring-divider steps per stage.
	localparam int ODD_W     = 8;
	localparam int SHIFT_W   = 5;
	localparam int DIV_STEPS = 4;

	// Register stages of the polynomial evaluator.
	localparam int POLY_STAGES = 8;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_CALIB_LOW  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_CALIB_MID  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_CALIB_HIGH = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_TEMP_OSR   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_PRES_OSR   = 3'd4;

	localparam logic [OSR_W-1:0] OSR_RESET = 3'd4;

	// Each datasheet scale factor is odd * 2^shift:
	// 524288 = 1<<19, 1572864 = 3<<19, 3670016 = 7<<19, 7864320 = 15<<19,
	// 253952 = 31<<13, 516096 = 63<<13, 1040384 = 127<<13, 2088960 = 255<<13.
	localparam logic [ODD_W-1:0] SCALE_ODD [8] = '{
		8'd1, 8'd3, 8'd7, 8'd15, 8'd31, 8'd63, 8'd127, 8'd255
	};
	localparam logic [SHIFT_W-1:0] SCALE_SHIFT [8] = '{
		5'd19, 5'd19, 5'd19, 5'd19, 5'd13, 5'd13, 5'd13, 5'd13
	};

	typedef struct packed {
		logic signed [11:0] c0;
		logic signed [11:0] c1;
		logic signed [19:0] c00;
		logic signed [19:0] c10;
		logic signed [15:0] c01;
		logic signed [15:0] c11;
		logic signed [15:0] c20;
		logic signed [15:0] c21;
		logic signed [15:0] c30;
	} coef_t;

	typedef struct packed {
		logic signed [RAW_W-1:0] raw_temperature;
		logic signed [RAW_W-1:0] raw_pressure;
	} sample_t;

	typedef struct packed {
		logic signed [TEMP_W-1:0] temperature;
		logic signed [PRES_W-1:0] pressure;
		logic                     saturated;
	} result_t;

endpackage

FILE: rtl/bpc_scaler.sv
// Raw sample to signed fixed point: magnitude, rounding offset, pipelined divide by the odd factor.
module bpc_scaler #(
	parameter int SCALED_FRACTION_BITS = 20
) (
	input  logic                                    clk,
	input  logic                                    adv,
	input  logic signed [bpc_pkg::RAW_W-1:0]        raw,
	input  logic        [bpc_pkg::OSR_W-1:0]        osr,
	output logic signed [SCALED_FRACTION_BITS+6:0]  scaled
);

	localparam int F          = SCALED_FRACTION_BITS;
	localparam int SUMW       = bpc_pkg::RAW_W + F;
	localparam int XW         = SUMW - 13;
	localparam int DIV_STAGES = (XW + bpc_pkg::DIV_STEPS - 1) / bpc_pkg::DIV_STEPS;
	localparam int DW         = DIV_STAGES * bpc_pkg::DIV_STEPS;
	localparam int QW         = F + 6;
	localparam int SW         = F + 7;
	localparam int OW         = bpc_pkg::ODD_W;

	logic [OW-1:0]                   odd;
	logic [bpc_pkg::SHIFT_W-1:0]     shamt;
	logic [bpc_pkg::RAW_W-1:0]       mag;
	logic [SUMW-1:0]                 half;
	logic [SUMW-1:0]                 sum;
	logic [XW-1:0]                   x_n;

	logic [DW-1:0]  x_s1;
	logic           neg_s1;
	logic [DW-1:0]  dwork_s [DIV_STAGES];
	logic [OW-1:0]  drem_s  [DIV_STAGES-1];
	logic           dneg_s  [DIV_STAGES];
	logic [SW-1:0]  qx;
	logic [SW-1:0]  scaled_s;

	// Round to nearest on the magnitude: add half of the factor, drop its power of two.
	always_comb begin
		odd   = bpc_pkg::SCALE_ODD[osr];
		shamt = bpc_pkg::SCALE_SHIFT[osr];
		mag   = raw[bpc_pkg::RAW_W-1] ? ($unsigned(~raw) + 1'b1) : $unsigned(raw);
		half  = SUMW'(odd) << (shamt - 5'd1);
		sum   = {mag, {F{1'b0}}} + half;
		x_n   = XW'(sum >> shamt);
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			x_s1   <= DW'(x_n);
			neg_s1 <= raw[bpc_pkg::RAW_W-1];
		end
	end

	// Restoring division by the odd factor, a few quotient bits per stage.
	for (genvar g = 0; g < DIV_STAGES; g++) begin : g_div
		logic [DW-1:0] work_in;
		logic [DW-1:0] work_nx;
		logic [OW-1:0] rem_in;
		logic [OW-1:0] rem_nx;
		logic          neg_in;

		if (g == 0) begin : g_first
			assign work_in = x_s1;
			assign rem_in  = '0;
			assign neg_in  = neg_s1;
		end else begin : g_next
			assign work_in = dwork_s[g-1];
			assign rem_in  = drem_s[g-1];
			assign neg_in  = dneg_s[g-1];
		end

		always_comb begin
			logic [OW:0] r;
			work_nx = work_in;
			rem_nx  = rem_in;
			r       = '0;
			for (int j = 0; j < bpc_pkg::DIV_STEPS; j++) begin
				r       = {rem_nx, work_nx[DW-1]};
				work_nx = {work_nx[DW-2:0], 1'b0};
				if (r >= {1'b0, odd}) begin
					r          = r - {1'b0, odd};
					work_nx[0] = 1'b1;
				end
				rem_nx = r[OW-1:0];
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				dwork_s[g] <= work_nx;
				dneg_s[g]  <= neg_in;
			end
		end

		if (g < DIV_STAGES - 1) begin : g_rem
			always_ff @(posedge clk) begin
				if (adv) begin
					drem_s[g] <= rem_nx;
				end
			end
		end
	end

	// Restore the sign.
	assign qx = {1'b0, dwork_s[DIV_STAGES-1][QW-1:0]};

	always_ff @(posedge clk) begin
		if (adv) begin
			scaled_s <= dneg_s[DIV_STAGES-1] ? (~qx + 1'b1) : qx;
		end
	end

	assign scaled = $signed(scaled_s);

endmodule

FILE: rtl/bpc_poly.sv
// Temperature formula and Horner pressure polynomial, eight register stages, saturating output.
module bpc_poly #(
	parameter int SCALED_FRACTION_BITS = 20
) (
	input  logic                                    clk,
	input  logic                                    adv,
	input  bpc_pkg::coef_t                          coef,
	input  logic signed [SCALED_FRACTION_BITS+6:0]  tsc,
	input  logic signed [SCALED_FRACTION_BITS+6:0]  psc,
	output bpc_pkg::result_t                        result
);

	localparam int F   = SCALED_FRACTION_BITS;
	localparam int SW  = F + 7;
	localparam int PAW = SW + 16;
	localparam int PTW = SW + 12;
	localparam int AW  = 30;
	localparam int TW  = 27;
	localparam int PBW = SW + AW;
	localparam int BW  = 34;
	localparam int BLO = 17;
	localparam int BHI = BW - BLO;
	localparam int PHW = SW + BHI;
	localparam int PLW = SW + BLO + 1;
	localparam int PXW = SW + BW;
	localparam int RW  = 39;
	localparam int PW  = 40;
	localparam int TOW = bpc_pkg::TEMP_W;
	localparam int POW = bpc_pkg::PRES_W;

	localparam logic signed [PAW:0] HALF_A = (PAW+1)'(1) << (F - 7);
	localparam logic signed [PTW:0] HALF_T = (PTW+1)'(1) << (F - 9);
	localparam logic signed [PBW:0] HALF_B = (PBW+1)'(1) << (F - 1);
	localparam logic signed [PXW:0] HALF_X = (PXW+1)'(1) << (F - 1);

	localparam logic [TOW-1:0] T_MAX = {1'b0, {(TOW-1){1'b1}}};
	localparam logic [TOW-1:0] T_MIN = {1'b1, {(TOW-1){1'b0}}};
	localparam logic [POW-1:0] P_MAX = {1'b0, {(POW-1){1'b1}}};
	localparam logic [POW-1:0] P_MIN = {1'b1, {(POW-1){1'b0}}};

	logic signed [PAW-1:0] pa_s1, pd_s1;
	logic signed [PTW-1:0] pt_s1;
	logic signed [SW-1:0]  psc_s1, tsc_s1, psc_s2, tsc_s2, psc_s3, tsc_s3, psc_s4, tsc_s4;
	logic signed [AW-1:0]  a_s2, d_s2;
	logic signed [TW-1:0]  t_s2, t_s3, t_s4, t_s5, t_s6, t_s7;
	logic signed [PBW-1:0] pb_s3, pe_s3;
	logic signed [BW-1:0]  b_s4, e_s4;
	logic signed [PHW-1:0] pbh_s5, peh_s5;
	logic signed [PLW-1:0] pbl_s5, pel_s5;
	logic signed [PXW-1:0] pbx_s6, pex_s6;
	logic signed [RW-1:0]  r1_s7, r2_s7;
	bpc_pkg::result_t      res_s8;

	logic signed [PAW:0]   ra_t, rd_t;
	logic signed [PTW:0]   rt_t;
	logic signed [PBW:0]   rb_t, re_t;
	logic signed [PXW:0]   rx1_t, rx2_t;
	logic signed [AW-1:0]  a_n, d_n;
	logic signed [TW-1:0]  t_n;
	logic signed [BW-1:0]  b_n, e_n;
	logic signed [PXW-1:0] pbx_n, pex_n;
	logic signed [RW-1:0]  r1_n, r2_n;
	logic signed [PW-1:0]  p_sum;
	logic                  t_ok, p_ok;
	bpc_pkg::result_t      res_n;

	// Rounding shifts: add half an output step, then shift arithmetically.
	always_comb begin
		ra_t = $signed({pa_s1[PAW-1], pa_s1}) + HALF_A;
		rd_t = $signed({pd_s1[PAW-1], pd_s1}) + HALF_A;
		rt_t = $signed({pt_s1[PTW-1], pt_s1}) + HALF_T;
		a_n  = AW'(ra_t >>> (F - 6)) + (AW'(coef.c20) <<< 6);
		d_n  = AW'(rd_t >>> (F - 6)) + (AW'(coef.c11) <<< 6);
		t_n  = TW'(rt_t >>> (F - 8)) + (TW'(coef.c0) <<< 7);

		rb_t = $signed({pb_s3[PBW-1], pb_s3}) + HALF_B;
		re_t = $signed({pe_s3[PBW-1], pe_s3}) + HALF_B;
		b_n  = BW'(rb_t >>> F) + (BW'(coef.c10) <<< 6);
		e_n  = BW'(re_t >>> F) + (BW'(coef.c01) <<< 6);

		pbx_n = (PXW'(pbh_s5) <<< BLO) + PXW'(pbl_s5);
		pex_n = (PXW'(peh_s5) <<< BLO) + PXW'(pel_s5);

		rx1_t = $signed({pbx_s6[PXW-1], pbx_s6}) + HALF_X;
		rx2_t = $signed({pex_s6[PXW-1], pex_s6}) + HALF_X;
		r1_n  = RW'(rx1_t >>> F);
		r2_n  = RW'(rx2_t >>> F);

		p_sum = (PW'(coef.c00) <<< 6) + PW'(r1_s7) + PW'(r2_s7);

		// Clip where the bits above the sign do not all agree.
		t_ok = (&t_s7[TW-1:TOW-1]) | ~(|t_s7[TW-1:TOW-1]);
		p_ok = (&p_sum[PW-1:POW-1]) | ~(|p_sum[PW-1:POW-1]);

		res_n.temperature = t_ok ? t_s7[TOW-1:0] : (t_s7[TW-1] ? T_MIN : T_MAX);
		res_n.pressure    = p_ok ? p_sum[POW-1:0] : (p_sum[PW-1] ? P_MIN : P_MAX);
		res_n.saturated   = ~t_ok | ~p_ok;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			// s1: first products
			pa_s1  <= psc * coef.c30;
			pd_s1  <= psc * coef.c21;
			pt_s1  <= tsc * coef.c1;
			psc_s1 <= psc;
			tsc_s1 <= tsc;
			// s2: inner Horner terms and temperature
			a_s2   <= a_n;
			d_s2   <= d_n;
			t_s2   <= t_n;
			psc_s2 <= psc_s1;
			tsc_s2 <= tsc_s1;
			// s3: second products
			pb_s3  <= psc_s2 * a_s2;
			pe_s3  <= psc_s2 * d_s2;
			t_s3   <= t_s2;
			psc_s3 <= psc_s2;
			tsc_s3 <= tsc_s2;
			// s4: middle Horner terms
			b_s4   <= b_n;
			e_s4   <= e_n;
			t_s4   <= t_s3;
			psc_s4 <= psc_s3;
			tsc_s4 <= tsc_s3;
			// s5: outer products split into high and low halves
			pbh_s5 <= psc_s4 * $signed(b_s4[BW-1:BLO]);
			pbl_s5 <= psc_s4 * $signed({1'b0, b_s4[BLO-1:0]});
			peh_s5 <= tsc_s4 * $signed(e_s4[BW-1:BLO]);
			pel_s5 <= tsc_s4 * $signed({1'b0, e_s4[BLO-1:0]});
			t_s5   <= t_s4;
			// s6: merge halves
			pbx_s6 <= pbx_n;
			pex_s6 <= pex_n;
			t_s6   <= t_s5;
			// s7: round outer terms
			r1_s7  <= r1_n;
			r2_s7  <= r2_n;
			t_s7   <= t_s6;
			// s8: final sum and clip
			res_s8 <= res_n;
		end
	end

	assign result = res_s8;

endmodule

FILE: rtl/barometric_pressure_compensation_core.sv
// Top level of the barometric pressure compensation core: config registers, pipeline, output queue.
//
//  channel  | handshake                 | payload                       | direction
//  ---------+---------------------------+-------------------------------+----------
//  sample   | sample_valid/sample_ready | raw_temperature, raw_pressure | in
//  result   | result_valid/result_ready | temperature, pressure, sat.   | out
//  cfg      | cfg_valid/cfg_ready       | cfg_index, cfg_data           | in
//
// One sample beat is taken per cycle while the pipeline advances. A beat passes through
// one front stage, the divider stages at four quotient bits each, one sign stage, eight
// polynomial stages and the output queue. arst_n clears the valid bits, the queue
// pointers and the config registers (calibration 0, oversampling code 4). The whole
// pipeline holds only when both output queue entries are full and result_ready is low.
module barometric_pressure_compensation_core #(
	parameter int SCALED_FRACTION_BITS = 20
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                sample_valid,
	output logic                                sample_ready,
	input  bpc_pkg::sample_t                    sample,
	output logic                                result_valid,
	input  logic                                result_ready,
	output bpc_pkg::result_t                    result,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [bpc_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [bpc_pkg::CFG_DATA_W-1:0]      cfg_data
);

	// Stage count of the scaler follows the width of the value it divides.
	localparam int F          = SCALED_FRACTION_BITS;
	localparam int SW         = F + 7;
	localparam int XW         = bpc_pkg::RAW_W + F - 13;
	localparam int DIV_STAGES = (XW + bpc_pkg::DIV_STEPS - 1) / bpc_pkg::DIV_STEPS;
	localparam int SC_STAGES  = DIV_STAGES + 2;
	localparam int TOTAL      = SC_STAGES + bpc_pkg::POLY_STAGES;

	logic [bpc_pkg::CALIB_W-1:0] calib_low_q, calib_mid_q, calib_high_q;
	logic [bpc_pkg::OSR_W-1:0]   t_osr_q, p_osr_q;
	logic [3*bpc_pkg::CALIB_W-1:0] cal_all;
	bpc_pkg::coef_t              coef;

	logic                  adv;
	logic [TOTAL-1:0]      stage_vld_q;
	logic signed [SW-1:0]  tsc, psc;
	bpc_pkg::result_t      poly_res;

	bpc_pkg::result_t      qbuf_q [2];
	logic                  wr_ptr_q, rd_ptr_q;
	logic [1:0]            cnt_q;
	logic                  push, pop;

	// Configuration: always ready, writes to unknown indexes drop.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			calib_low_q  <= '0;
			calib_mid_q  <= '0;
			calib_high_q <= '0;
			t_osr_q      <= bpc_pkg::OSR_RESET;
			p_osr_q      <= bpc_pkg::OSR_RESET;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				bpc_pkg::REG_CALIB_LOW:  calib_low_q  <= cfg_data;
				bpc_pkg::REG_CALIB_MID:  calib_mid_q  <= cfg_data;
				bpc_pkg::REG_CALIB_HIGH: calib_high_q <= cfg_data;
				bpc_pkg::REG_TEMP_OSR:   t_osr_q      <= cfg_data[bpc_pkg::OSR_W-1:0];
				bpc_pkg::REG_PRES_OSR:   p_osr_q      <= cfg_data[bpc_pkg::OSR_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// Unpack the coefficients from the big-endian byte string, byte 0 on top.
	always_comb begin
		cal_all  = {calib_low_q, calib_mid_q, calib_high_q};
		coef.c0  = $signed(cal_all[143:132]);
		coef.c1  = $signed(cal_all[131:120]);
		coef.c00 = $signed(cal_all[119:100]);
		coef.c10 = $signed(cal_all[99:80]);
		coef.c01 = $signed(cal_all[79:64]);
		coef.c11 = $signed(cal_all[63:48]);
		coef.c20 = $signed(cal_all[47:32]);
		coef.c21 = $signed(cal_all[31:16]);
		coef.c30 = $signed(cal_all[15:0]);
	end

	// Advance every stage together unless the queue is full and nobody drains it.
	assign adv          = (cnt_q != 2'd2) || result_ready;
	assign sample_ready = adv;

	// Valid bits ride along with the stages; bubbles advance as empty slots.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stage_vld_q <= '0;
		end else if (adv) begin
			stage_vld_q <= {stage_vld_q[TOTAL-2:0], sample_valid};
		end
	end

	bpc_scaler #(
		.SCALED_FRACTION_BITS (SCALED_FRACTION_BITS)
	) u_scale_t (
		.clk    (clk),
		.adv    (adv),
		.raw    (sample.raw_temperature),
		.osr    (t_osr_q),
		.scaled (tsc)
	);

	bpc_scaler #(
		.SCALED_FRACTION_BITS (SCALED_FRACTION_BITS)
	) u_scale_p (
		.clk    (clk),
		.adv    (adv),
		.raw    (sample.raw_pressure),
		.osr    (p_osr_q),
		.scaled (psc)
	);

	bpc_poly #(
		.SCALED_FRACTION_BITS (SCALED_FRACTION_BITS)
	) u_poly (
		.clk    (clk),
		.adv    (adv),
		.coef   (coef),
		.tsc    (tsc),
		.psc    (psc),
		.result (poly_res)
	);

	// Two-entry output queue: the pipeline keeps moving while one result beat waits.
	assign push         = adv && stage_vld_q[TOTAL-1];
	assign result_valid = (cnt_q != 2'd0);
	assign pop          = result_valid && result_ready;
	assign result       = qbuf_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			qbuf_q[wr_ptr_q] <= poly_res;
		end
	end

endmodule

FILE: verif/bpc_checker.sv
// Scoreboard for the pressure compensation core: shadows the registers, predicts and compares.
`timescale 1ns / 1ps

module bpc_checker #(
	parameter int SCALED_FRACTION_BITS = 20
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           sample_valid,
	input  logic                           sample_ready,
	input  bpc_pkg::sample_t               sample,
	input  logic                           result_valid,
	input  logic                           result_ready,
	input  bpc_pkg::result_t               result,
	input  logic                           cfg_valid,
	input  logic                           cfg_ready,
	input  logic [bpc_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [bpc_pkg::CFG_DATA_W-1:0] cfg_data,
	output int                             mismatches,
	output int                             pending,
	output int                             checked,
	output int                             saturated_seen
);

	localparam int TEMP_FRAC   = 8;
	localparam int PRES_FRAC   = 6;
	localparam int MAX_REPORTS = 10;

	localparam longint OSR_DIVISOR [8] = '{
		524288, 1572864, 3670016, 7864320, 253952, 516096, 1040384, 2088960
	};
	localparam longint TEMP_HI = (longint'(1) << (bpc_pkg::TEMP_W - 1)) - 1;
	localparam longint TEMP_LO = -TEMP_HI - 1;
	localparam longint PRES_HI = (longint'(1) << (bpc_pkg::PRES_W - 1)) - 1;
	localparam longint PRES_LO = -PRES_HI - 1;

	logic [bpc_pkg::CALIB_W-1:0] calib_low  = '0;
	logic [bpc_pkg::CALIB_W-1:0] calib_mid  = '0;
	logic [bpc_pkg::CALIB_W-1:0] calib_high = '0;
	logic [bpc_pkg::OSR_W-1:0]   temp_osr   = bpc_pkg::OSR_RESET;
	logic [bpc_pkg::OSR_W-1:0]   pres_osr   = bpc_pkg::OSR_RESET;

	bpc_pkg::result_t expected_readings [$];
	bpc_pkg::result_t want;

	initial begin
		mismatches     = 0;
		pending        = 0;
		checked        = 0;
		saturated_seen = 0;
	end

	// Divide on the magnitude, round to nearest with ties away from zero.
	function automatic longint scale_raw(longint raw, logic [bpc_pkg::OSR_W-1:0] code);
		longint divisor, mag, q;
		divisor = OSR_DIVISOR[code];
		mag = (raw < 0) ? -raw : raw;
		q = ((mag << SCALED_FRACTION_BITS) + divisor / 2) / divisor;
		return (raw < 0) ? -q : q;
	endfunction

	// Round to nearest, ties toward plus infinity.
	function automatic longint round_half_up(longint x, int s);
		return (x + (longint'(1) << (s - 1))) >>> s;
	endfunction

	function automatic bpc_pkg::result_t compensate_sample(bpc_pkg::sample_t s);
		bpc_pkg::coef_t   c;
		longint           t_sc, p_sc, temp, a, b, d, e, pres;
		logic             sat;
		bpc_pkg::result_t r;
		c    = bpc_pkg::coef_t'({calib_low, calib_mid, calib_high});
		t_sc = scale_raw(longint'(s.raw_temperature), temp_osr);
		p_sc = scale_raw(longint'(s.raw_pressure), pres_osr);
		temp = longint'(c.c0) * 128
			+ round_half_up(longint'(c.c1) * t_sc, SCALED_FRACTION_BITS - TEMP_FRAC);
		a = longint'(c.c20) * 64
			+ round_half_up(p_sc * longint'(c.c30), SCALED_FRACTION_BITS - PRES_FRAC);
		b = longint'(c.c10) * 64 + round_half_up(p_sc * a, SCALED_FRACTION_BITS);
		d = longint'(c.c11) * 64
			+ round_half_up(p_sc * longint'(c.c21), SCALED_FRACTION_BITS - PRES_FRAC);
		e = longint'(c.c01) * 64 + round_half_up(p_sc * d, SCALED_FRACTION_BITS);
		pres = longint'(c.c00) * 64 + round_half_up(p_sc * b, SCALED_FRACTION_BITS)
			+ round_half_up(t_sc * e, SCALED_FRACTION_BITS);
		sat = 1'b0;
		if (temp > TEMP_HI) begin
			temp = TEMP_HI;
			sat  = 1'b1;
		end else if (temp < TEMP_LO) begin
			temp = TEMP_LO;
			sat  = 1'b1;
		end
		if (pres > PRES_HI) begin
			pres = PRES_HI;
			sat  = 1'b1;
		end else if (pres < PRES_LO) begin
			pres = PRES_LO;
			sat  = 1'b1;
		end
		r.temperature = temp[bpc_pkg::TEMP_W-1:0];
		r.pressure    = pres[bpc_pkg::PRES_W-1:0];
		r.saturated   = sat;
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			calib_low  = '0;
			calib_mid  = '0;
			calib_high = '0;
			temp_osr   = bpc_pkg::OSR_RESET;
			pres_osr   = bpc_pkg::OSR_RESET;
			expected_readings.delete();
			pending = 0;
		end else begin
			if (result_valid && result_ready) begin
				if (expected_readings.size() == 0) begin
					mismatches++;
					if (mismatches <= MAX_REPORTS)
						$display("%0t: result beat with nothing expected: T=%0d P=%0d sat=%0b",
							$realtime, result.temperature, result.pressure, result.saturated);
				end else begin
					want = expected_readings.pop_front();
					checked++;
					if (result.saturated === 1'b1)
						saturated_seen++;
					if (result.temperature !== want.temperature ||
						result.pressure !== want.pressure ||
						result.saturated !== want.saturated) begin
						mismatches++;
						if (mismatches <= MAX_REPORTS)
							$display({"%0t: result %0d expected T=%0d P=%0d sat=%0b,",
								" got T=%0d P=%0d sat=%0b"},
								$realtime, checked, want.temperature, want.pressure,
								want.saturated, result.temperature, result.pressure,
								result.saturated);
					end
				end
			end
			if (sample_valid && sample_ready)
				expected_readings.push_back(compensate_sample(sample));
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					bpc_pkg::REG_CALIB_LOW:  calib_low  = cfg_data[bpc_pkg::CALIB_W-1:0];
					bpc_pkg::REG_CALIB_MID:  calib_mid  = cfg_data[bpc_pkg::CALIB_W-1:0];
					bpc_pkg::REG_CALIB_HIGH: calib_high = cfg_data[bpc_pkg::CALIB_W-1:0];
					bpc_pkg::REG_TEMP_OSR:   temp_osr   = cfg_data[bpc_pkg::OSR_W-1:0];
					bpc_pkg::REG_PRES_OSR:   pres_osr   = cfg_data[bpc_pkg::OSR_W-1:0];
					default: ;
				endcase
			end
			pending = expected_readings.size();
		end
	end

endmodule

FILE: verif/testbench.sv
// Top of the compensation core testbench: clock, reset, stimulus, backpressure and verdict.
`timescale 1ns / 1ps

module testbench;

	localparam int FRAC_BITS      = 20;
	// Pipeline depth of the core, plus slack for the final drain.
	localparam int LATENCY        = (FRAC_BITS + 14) / 4 + 11;
	localparam int DRAIN_CYCLES   = LATENCY + 10;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int PHASES         = 8;
	localparam int PHASE_ITEMS    = 191;
	localparam int CALIB_BYTES_W  = 3 * bpc_pkg::CALIB_W;

	// Raw sample corners: most negative, most positive, zero, minus one.
	localparam logic signed [bpc_pkg::RAW_W-1:0] RAW_EXTREMES [4] = '{
		24'sh800000, 24'sh7FFFFF, 24'sh000000, 24'shFFFFFF
	};
	// Calibration images with every coefficient at its positive or negative limit.
	localparam logic [CALIB_BYTES_W-1:0] COEF_MAX = {
		12'h7FF, 12'h7FF, 20'h7FFFF, 20'h7FFFF, {5{16'h7FFF}}
	};
	localparam logic [CALIB_BYTES_W-1:0] COEF_MIN = {
		12'h800, 12'h800, 20'h80000, 20'h80000, {5{16'h8000}}
	};

	logic                           clk = 1'b0;
	logic                           arst_n;
	logic                           sample_valid;
	logic                           sample_ready;
	bpc_pkg::sample_t               sample;
	logic                           result_valid;
	logic                           result_ready;
	bpc_pkg::result_t               result;
	logic                           cfg_valid;
	logic                           cfg_ready;
	logic [bpc_pkg::CFG_IDX_W-1:0]  cfg_index;
	logic [bpc_pkg::CFG_DATA_W-1:0] cfg_data;

	int mismatches;
	int pending;
	int checked;
	int saturated_seen;

	int sender_gap_max = 5;
	int sink_gap_max   = 5;
	int samples_sent   = 0;
	int calib_sets     = 0;
	int quiet_cycles   = 0;

	always #5 clk = ~clk;

	barometric_pressure_compensation_core #(
		.SCALED_FRACTION_BITS(FRAC_BITS)
	) i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.sample_valid (sample_valid),
		.sample_ready (sample_ready),
		.sample       (sample),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	bpc_checker #(
		.SCALED_FRACTION_BITS(FRAC_BITS)
	) i_checker (
		.clk            (clk),
		.arst_n         (arst_n),
		.sample_valid   (sample_valid),
		.sample_ready   (sample_ready),
		.sample         (sample),
		.result_valid   (result_valid),
		.result_ready   (result_ready),
		.result         (result),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.mismatches     (mismatches),
		.pending        (pending),
		.checked        (checked),
		.saturated_seen (saturated_seen)
	);

	// Present one sample beat after a random gap. Valid is left high on return so
	// that a zero-gap follower keeps it high without a glitch; callers that stop
	// sending drop it themselves.
	task automatic present_sample(logic signed [bpc_pkg::RAW_W-1:0] raw_t,
		logic signed [bpc_pkg::RAW_W-1:0] raw_p);
		int gap;
		gap = $urandom_range(0, sender_gap_max);
		if (gap > 0) begin
			sample_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		sample_valid         <= 1'b1;
		sample.raw_temperature <= raw_t;
		sample.raw_pressure    <= raw_p;
		@(posedge clk);
		while (!sample_ready)
			@(posedge clk);
		@(negedge clk);
		samples_sent++;
	endtask

	// Drop valid and hold off until every predicted reading has been returned.
	task automatic drain_results();
		sample_valid <= 1'b0;
		while (pending != 0)
			@(negedge clk);
	endtask

	// Write one register; cfg_valid stays high so back-to-back writes need no toggle.
	task automatic write_reg(logic [bpc_pkg::CFG_IDX_W-1:0] idx,
		logic [bpc_pkg::CFG_DATA_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		@(negedge clk);
	endtask

	// Load a full calibration image and both oversampling codes while the core is
	// empty. Junk goes into the unused upper bits of the code writes, and one write
	// to an unmapped index must leave everything untouched.
	task automatic program_calibration(logic [CALIB_BYTES_W-1:0] image,
		logic [bpc_pkg::OSR_W-1:0] t_code, logic [bpc_pkg::OSR_W-1:0] p_code);
		logic [bpc_pkg::CFG_DATA_W-1:0] junk;
		drain_results();
		write_reg(bpc_pkg::REG_CALIB_LOW,  image[3*bpc_pkg::CALIB_W-1:2*bpc_pkg::CALIB_W]);
		write_reg(bpc_pkg::REG_CALIB_MID,  image[2*bpc_pkg::CALIB_W-1:bpc_pkg::CALIB_W]);
		write_reg(bpc_pkg::REG_CALIB_HIGH, image[bpc_pkg::CALIB_W-1:0]);
		junk = {$urandom, $urandom};
		junk[bpc_pkg::OSR_W-1:0] = t_code;
		write_reg(bpc_pkg::REG_TEMP_OSR, junk);
		junk = {$urandom, $urandom};
		junk[bpc_pkg::OSR_W-1:0] = p_code;
		write_reg(bpc_pkg::REG_PRES_OSR, junk);
		write_reg(bpc_pkg::REG_PRES_OSR + bpc_pkg::CFG_IDX_W'($urandom_range(1, 3)),
			{$urandom, $urandom});
		cfg_valid <= 1'b0;
		calib_sets++;
	endtask

	// Mix of full-range words, realistic small readings and hard corners.
	function automatic logic signed [bpc_pkg::RAW_W-1:0] draw_raw();
		int pick;
		int near_zero;
		pick = $urandom_range(0, 3);
		case (pick)
			0, 1: return bpc_pkg::RAW_W'($urandom);
			2: begin
				near_zero = int'($urandom_range(0, 131071)) - 65536;
				return bpc_pkg::RAW_W'(near_zero);
			end
			default: return RAW_EXTREMES[$urandom_range(0, 3)];
		endcase
	endfunction

	// Sink: draw a stall before each result beat, then accept it.
	initial begin
		int stall;
		result_ready = 1'b0;
		wait (arst_n === 1'b1);
		@(negedge clk);
		forever begin
			stall = $urandom_range(0, sink_gap_max);
			if (stall > 0) begin
				result_ready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			result_ready <= 1'b1;
			@(posedge clk);
			while (!result_valid)
				@(posedge clk);
			@(negedge clk);
		end
	end

	// Watchdog: end the run if no channel moves a beat for too long.
	always @(posedge clk) begin
		if (!arst_n || (sample_valid && sample_ready) || (result_valid && result_ready) ||
			(cfg_valid && cfg_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("%0t: no beat on any channel for %0d cycles", $realtime, quiet_cycles);
			$display("FAILED: results differ");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		logic [CALIB_BYTES_W-1:0] image;
		int i, j, phase, n;

		arst_n       = 1'b0;
		sample_valid = 1'b0;
		sample       = '0;
		cfg_valid    = 1'b0;
		cfg_index    = '0;
		cfg_data     = '0;
		repeat (2) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Reset state: zero calibration, both codes at their reset value.
		present_sample(RAW_EXTREMES[1], RAW_EXTREMES[1]);
		present_sample(RAW_EXTREMES[0], 24'sd1);

		// Every corner pairing of the raw samples against a random calibration,
		// with the smallest divisor so the scaled values are largest.
		image = {$urandom, $urandom, $urandom, $urandom, 16'($urandom)};
		program_calibration(image, 3'd4, 3'd4);
		for (i = 0; i < 4; i++)
			for (j = 0; j < 4; j++)
				present_sample(RAW_EXTREMES[i], RAW_EXTREMES[j]);

		// Coefficients at their limits: drive both outputs into clipping.
		program_calibration(COEF_MAX, 3'd4, 3'd4);
		present_sample(RAW_EXTREMES[1], RAW_EXTREMES[1]);
		present_sample(RAW_EXTREMES[0], RAW_EXTREMES[1]);
		present_sample(RAW_EXTREMES[0], RAW_EXTREMES[0]);
		program_calibration(COEF_MIN, 3'd4, 3'd4);
		present_sample(RAW_EXTREMES[1], RAW_EXTREMES[0]);
		present_sample(RAW_EXTREMES[0], RAW_EXTREMES[1]);
		present_sample(RAW_EXTREMES[1], RAW_EXTREMES[1]);

		// Random phases: each walks a different pair of oversampling codes so
		// both channels see all eight, with all-ones and all-zero images mixed in.
		for (phase = 0; phase < PHASES; phase++) begin
			case (phase)
				2:       image = '1;
				5:       image = '0;
				default: image = {$urandom, $urandom, $urandom, $urandom, 16'($urandom)};
			endcase
			program_calibration(image, bpc_pkg::OSR_W'(phase),
				bpc_pkg::OSR_W'(PHASES - 1 - phase));
			for (n = 0; n < PHASE_ITEMS; n++) begin
				// Redraw the idle ceilings now and then so full-rate stretches
				// alternate with bursty ones on both sides.
				if (n % 48 == 0) begin
					sender_gap_max = ($urandom_range(0, 1) == 1) ? 5 : 0;
					sink_gap_max   = ($urandom_range(0, 1) == 1) ? 5 : 0;
				end
				if ($urandom_range(0, 249) == 0)
					drain_results();
				present_sample(draw_raw(), draw_raw());
			end
		end

		drain_results();
		repeat (DRAIN_CYCLES) @(negedge clk);

		$display("Sent %0d sample beats over %0d calibration images,", samples_sent,
			calib_sets);
		$display("every oversampling code on both inputs; checked %0d readings, %0d clipped.",
			checked, saturated_seen);
		if (mismatches == 0 && pending == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

endmodule
